>>> design/wspd_pkg.sv
// Shared types, constants and microcode for the wheel speed PID drive.
// Holds the config record, the control word layout and the step program.
// No dependencies.
`timescale 1ns / 1ps

package wspd_pkg;

  localparam int FRAC_BITS = 16;

  localparam int POS_W   = 32;
  localparam int SUM_W   = 40;
  localparam int SUM_LO  = 20;
  localparam int OPND_W  = 33;
  localparam int PROD_W  = 2 * OPND_W;
  localparam int PART_W  = 72;
  localparam int ACC_W   = 64;
  localparam int DUTY_W  = 8;

  // register index codes
  localparam logic [2:0] REG_LIN_SPEED = 3'd0;
  localparam logic [2:0] REG_ANG_SPEED = 3'd1;
  localparam logic [2:0] REG_INV_RAD   = 3'd2;
  localparam logic [2:0] REG_HALF_TW   = 3'd3;
  localparam logic [2:0] REG_CNT_SPEED = 3'd4;
  localparam logic [2:0] REG_GAIN_P    = 3'd5;
  localparam logic [2:0] REG_GAIN_I    = 3'd6;
  localparam logic [2:0] REG_GAIN_D    = 3'd7;

  localparam logic signed [31:0] RST_LIN_SPEED = 32'sd1311;
  localparam logic signed [31:0] RST_ANG_SPEED = 32'sd0;
  localparam logic [30:0]        RST_INV_RAD   = 31'd4096000;
  localparam logic [30:0]        RST_HALF_TW   = 31'd3178;
  localparam logic [30:0]        RST_CNT_SPEED = 31'd490;
  localparam logic signed [31:0] RST_GAIN_P    = 32'sd0;
  localparam logic signed [31:0] RST_GAIN_I    = 32'sd655360;
  localparam logic signed [31:0] RST_GAIN_D    = 32'sd0;

  localparam logic signed [PART_W-1:0] TERM_LIM   = 72'sh00_2000_0000_0000_0000;
  localparam logic signed [PART_W-1:0] TERM_LIM_N = -TERM_LIM;
  localparam logic signed [ACC_W-1:0]  DRIVE_LIM  = 64'sd255 <<< (2 * FRAC_BITS);
  localparam logic signed [ACC_W-1:0]  DRIVE_LIM_N = -DRIVE_LIM;

  typedef struct packed {
    logic signed [31:0] lin_speed;
    logic signed [31:0] ang_speed;
    logic [30:0]        inv_rad;
    logic [30:0]        half_tw;
    logic [30:0]        cnt_speed;
    logic signed [31:0] gain_p;
    logic signed [31:0] gain_i;
    logic signed [31:0] gain_d;
  } cfg_t;

  // multiplier operand selects
  typedef enum logic [2:0] {
    MA_DELTA, MA_HTW, MA_TMP, MA_ERR, MA_DERIV, MA_SUMHI, MA_SUMLO
  } ma_e;

  typedef enum logic [2:0] {
    MB_CTS, MB_W, MB_IR, MB_KP, MB_KI, MB_KD
  } mb_e;

  typedef enum logic [3:0] {
    OP_NOP, OP_DELTA, OP_MEAS, OP_SHIFT, OP_LIN, OP_ERR, OP_DERIV,
    OP_TERM0, OP_PART, OP_PARTSUM, OP_PSAT, OP_ACCPART, OP_DRIVE
  } op_e;

  typedef enum logic {
    J_NEXT, J_WHEEL
  } jmp_e;

  typedef struct packed {
    ma_e  ma;
    mb_e  mb;
    op_e  op;
    jmp_e jmp;
  } ucw_t;

  typedef struct packed {
    logic busy;
    logic side;
    logic adv;
    logic publish;
  } seq_t;

  localparam int UCODE_LEN = 17;
  localparam int UPC_W     = $clog2(UCODE_LEN);

  // One wheel's program. The product of a step is ready in the next step.
  function automatic ucw_t ucode(input logic [UPC_W-1:0] pc);
    ucw_t w;
    w = '{ma: MA_DELTA, mb: MB_CTS, op: OP_NOP, jmp: J_NEXT};
    unique case (pc)
      UPC_W'(0):  w.op = OP_DELTA;
      UPC_W'(1):  w.op = OP_NOP;
      UPC_W'(2):  begin w.ma = MA_HTW; w.mb = MB_W; w.op = OP_MEAS; end
      UPC_W'(3):  w.op = OP_SHIFT;
      UPC_W'(4):  w.op = OP_LIN;
      UPC_W'(5):  begin w.ma = MA_TMP; w.mb = MB_IR; end
      UPC_W'(6):  w.op = OP_SHIFT;
      UPC_W'(7):  w.op = OP_ERR;
      UPC_W'(8):  w.op = OP_DERIV;
      UPC_W'(9):  begin w.ma = MA_ERR; w.mb = MB_KP; end
      UPC_W'(10): begin w.ma = MA_SUMHI; w.mb = MB_KI; w.op = OP_TERM0; end
      UPC_W'(11): begin w.ma = MA_SUMLO; w.mb = MB_KI; w.op = OP_PART; end
      UPC_W'(12): begin w.ma = MA_DERIV; w.mb = MB_KD; w.op = OP_PARTSUM; end
      UPC_W'(13): begin w.ma = MA_DERIV; w.mb = MB_KD; w.op = OP_ACCPART; end
      UPC_W'(14): w.op = OP_PSAT;
      UPC_W'(15): w.op = OP_ACCPART;
      UPC_W'(16): begin w.op = OP_DRIVE; w.jmp = J_WHEEL; end
      default:    w.jmp = J_WHEEL;
    endcase
    return w;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] x);
    if ((&x[PROD_W-1:31]) || !(|x[PROD_W-1:31])) begin
      return x[31:0];
    end
    return x[PROD_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
  endfunction

  function automatic logic signed [PART_W-1:0] sat_term(input logic signed [PART_W-1:0] x);
    priority if (x > TERM_LIM) begin
      return TERM_LIM;
    end else if (x < TERM_LIM_N) begin
      return TERM_LIM_N;
    end else begin
      return x;
    end
  endfunction

endpackage

>>> design/wspd_cfg.sv
// Configuration register file for the wheel speed PID drive.
// Depends on wspd_pkg for the register codes, reset values and cfg_t.
`timescale 1ns / 1ps

module wspd_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  output wspd_pkg::cfg_t     cfg_o
);
  import wspd_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lin_speed <= RST_LIN_SPEED;
      cfg_q.ang_speed <= RST_ANG_SPEED;
      cfg_q.inv_rad   <= RST_INV_RAD;
      cfg_q.half_tw   <= RST_HALF_TW;
      cfg_q.cnt_speed <= RST_CNT_SPEED;
      cfg_q.gain_p    <= RST_GAIN_P;
      cfg_q.gain_i    <= RST_GAIN_I;
      cfg_q.gain_d    <= RST_GAIN_D;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LIN_SPEED: cfg_q.lin_speed <= cfg_wdata_i;
        REG_ANG_SPEED: cfg_q.ang_speed <= cfg_wdata_i;
        REG_INV_RAD:   cfg_q.inv_rad   <= cfg_wdata_i[30:0];
        REG_HALF_TW:   cfg_q.half_tw   <= cfg_wdata_i[30:0];
        REG_CNT_SPEED: cfg_q.cnt_speed <= cfg_wdata_i[30:0];
        REG_GAIN_P:    cfg_q.gain_p    <= cfg_wdata_i;
        REG_GAIN_I:    cfg_q.gain_i    <= cfg_wdata_i;
        REG_GAIN_D:    cfg_q.gain_d    <= cfg_wdata_i;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> design/wspd_seq.sv
// Microcode sequencer: step counter, wheel select and busy flag. Reads the
// step program from wspd_pkg; one control word per cycle while not stalled.
`timescale 1ns / 1ps

module wspd_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            out_blocked_i,
  output wspd_pkg::ucw_t  cw_o,
  output wspd_pkg::seq_t  seq_o
);
  import wspd_pkg::*;

  logic [UPC_W-1:0] pc_q;
  logic             side_q;
  logic             busy_q;
  ucw_t             cw;
  logic             hold;
  logic             adv;

  always_comb begin
    cw   = ucode(pc_q);
    // the last step of the right wheel waits for the output register
    hold = (cw.jmp == J_WHEEL) && side_q && out_blocked_i;
    adv  = busy_q && !hold;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= '0;
      side_q <= 1'b0;
      busy_q <= 1'b0;
    end else if (start_i) begin
      pc_q   <= '0;
      side_q <= 1'b0;
      busy_q <= 1'b1;
    end else if (adv) begin
      unique case (cw.jmp)
        J_NEXT:  pc_q <= pc_q + 1'b1;
        J_WHEEL: begin
          pc_q <= '0;
          if (side_q) begin
            busy_q <= 1'b0;
          end else begin
            side_q <= 1'b1;
          end
        end
      endcase
    end
  end

  assign cw_o          = cw;
  assign seq_o.busy    = busy_q;
  assign seq_o.side    = side_q;
  assign seq_o.adv     = adv;
  assign seq_o.publish = adv && (cw.jmp == J_WHEEL) && side_q;

endmodule

>>> design/wspd_dp.sv
// Datapath: shared registered multiplier, saturating adders, wheel state
// and output register. Driven by control words from wspd_seq; uses wspd_pkg.
`timescale 1ns / 1ps

module wspd_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  wspd_pkg::cfg_t            cfg_i,
  input  wspd_pkg::ucw_t            cw_i,
  input  wspd_pkg::seq_t            seq_i,
  input  logic                      start_i,
  input  logic signed [31:0]        left_position_i,
  input  logic signed [31:0]        right_position_i,
  input  logic                      out_stall_i,
  output logic                      out_valid_o,
  output logic [7:0]                left_duty_o,
  output logic                      left_reverse_o,
  output logic [7:0]                right_duty_o,
  output logic                      right_reverse_o
);
  import wspd_pkg::*;

  logic [POS_W-1:0]         pos_q  [2];
  logic [POS_W-1:0]         last_q [2];
  logic signed [31:0]       prev_q [2];
  logic signed [SUM_W-1:0]  esum_q [2];

  logic signed [31:0]       delta_q, meas_q, tmp_q, err_q;
  logic signed [32:0]       deriv_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [PART_W-1:0] part_q;
  logic signed [ACC_W-1:0]  acc_q;

  logic [DUTY_W-1:0]        ldut_q;
  logic                     lrev_q;
  logic                     out_valid_q;

  logic signed [OPND_W-1:0] mul_a, mul_b;
  logic                     side;
  logic signed [32:0]       lin_sum, err_diff;
  logic signed [SUM_W:0]    sum_ext;
  logic signed [SUM_W-1:0]  sum_sat;
  logic signed [PART_W-1:0] prod_ext;
  logic signed [ACC_W-1:0]  drv, mag;
  logic [DUTY_W-1:0]        duty;
  logic                     rev;

  assign side = seq_i.side;

  always_comb begin
    unique case (cw_i.ma)
      MA_DELTA: mul_a = {delta_q[31], delta_q};
      MA_HTW:   mul_a = {2'b00, cfg_i.half_tw};
      MA_TMP:   mul_a = {tmp_q[31], tmp_q};
      MA_ERR:   mul_a = {err_q[31], err_q};
      MA_DERIV: mul_a = deriv_q;
      MA_SUMHI: mul_a = {{(OPND_W-SUM_W+SUM_LO){sum_q[SUM_W-1]}}, sum_q[SUM_W-1:SUM_LO]};
      MA_SUMLO: mul_a = {{(OPND_W-SUM_LO){1'b0}}, sum_q[SUM_LO-1:0]};
      default:  mul_a = '0;
    endcase
    unique case (cw_i.mb)
      MB_CTS:  mul_b = {2'b00, cfg_i.cnt_speed};
      MB_W:    mul_b = {cfg_i.ang_speed[31], cfg_i.ang_speed};
      MB_IR:   mul_b = {2'b00, cfg_i.inv_rad};
      MB_KP:   mul_b = {cfg_i.gain_p[31], cfg_i.gain_p};
      MB_KI:   mul_b = {cfg_i.gain_i[31], cfg_i.gain_i};
      MB_KD:   mul_b = {cfg_i.gain_d[31], cfg_i.gain_d};
      default: mul_b = '0;
    endcase
  end

  always_comb begin
    // left wheel subtracts the turn component, right wheel adds it
    if (side) begin
      lin_sum = {cfg_i.lin_speed[31], cfg_i.lin_speed} + {tmp_q[31], tmp_q};
    end else begin
      lin_sum = {cfg_i.lin_speed[31], cfg_i.lin_speed} - {tmp_q[31], tmp_q};
    end
    err_diff = {tmp_q[31], tmp_q} - {meas_q[31], meas_q};

    sum_ext = {esum_q[side][SUM_W-1], esum_q[side]}
            + {{(SUM_W-31){err_q[31]}}, err_q};
    if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
      sum_sat = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_sat = sum_ext[SUM_W-1:0];
    end

    prod_ext = {{(PART_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};

    priority if (acc_q > DRIVE_LIM) begin
      drv = DRIVE_LIM;
    end else if (acc_q < DRIVE_LIM_N) begin
      drv = DRIVE_LIM_N;
    end else begin
      drv = acc_q;
    end
    mag  = drv[ACC_W-1] ? -drv : drv;
    duty = mag[2*FRAC_BITS +: DUTY_W];
    rev  = drv[ACC_W-1] || (drv == '0);
  end

  // payload and working registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      pos_q[0] <= left_position_i;
      pos_q[1] <= right_position_i;
    end
    if (seq_i.adv) begin
      prod_q <= mul_a * mul_b;
      unique case (cw_i.op)
        OP_NOP:     ;
        OP_DELTA:   delta_q <= pos_q[side] - last_q[side];
        OP_MEAS:    meas_q  <= sat32(prod_q);
        OP_SHIFT:   tmp_q   <= sat32(prod_q >>> FRAC_BITS);
        OP_LIN:     tmp_q   <= sat32({{(PROD_W-33){lin_sum[32]}}, lin_sum});
        OP_ERR:     err_q   <= sat32({{(PROD_W-33){err_diff[32]}}, err_diff});
        OP_DERIV: begin
          deriv_q <= {err_q[31], err_q} - {prev_q[side][31], prev_q[side]};
          sum_q   <= sum_sat;
        end
        OP_TERM0:   acc_q  <= ACC_W'(sat_term(prod_ext));
        OP_PART:    part_q <= prod_ext <<< SUM_LO;
        OP_PARTSUM: part_q <= sat_term(part_q + prod_ext);
        OP_PSAT:    part_q <= sat_term(prod_ext);
        OP_ACCPART: acc_q  <= acc_q + part_q[ACC_W-1:0];
        OP_DRIVE: begin
          if (side) begin
            left_duty_o     <= ldut_q;
            left_reverse_o  <= lrev_q;
            right_duty_o    <= duty;
            right_reverse_o <= rev;
          end else begin
            ldut_q <= duty;
            lrev_q <= rev;
          end
        end
        default: ;
      endcase
    end
  end

  // wheel history, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q[0] <= '0;
      last_q[1] <= '0;
      prev_q[0] <= '0;
      prev_q[1] <= '0;
      esum_q[0] <= '0;
      esum_q[1] <= '0;
    end else if (seq_i.adv && (cw_i.op == OP_DRIVE)) begin
      last_q[side] <= pos_q[side];
      prev_q[side] <= err_q;
      esum_q[side] <= sum_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (seq_i.publish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> design/wheel_speed_pid_drive.sv
// Wheel speed PID drive, top level: config registers, sequencer, datapath.
// Each wheel runs the 17-step program in turn, left then right; the input stalls while busy,
// so items do not overlap: the single shared multiplier is reused by the step program
// for both wheels; a stalled output holds the last step.
// Reset clears config to defaults, wheel history to zero, and the channels to idle.
// Depends on wspd_pkg, wspd_cfg, wspd_seq and wspd_dp.
`timescale 1ns / 1ps

module wheel_speed_pid_drive (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] left_position_i,
  input  logic signed [31:0] right_position_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         left_duty_o,
  output logic               left_reverse_o,
  output logic [7:0]         right_duty_o,
  output logic               right_reverse_o
);
  import wspd_pkg::*;

  cfg_t cfg;
  ucw_t cw;
  seq_t seq;
  logic start;

  assign start      = in_valid_i && !seq.busy;
  assign in_stall_o = seq.busy;

  wspd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  wspd_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .out_blocked_i (out_valid_o && out_stall_i),
    .cw_o          (cw),
    .seq_o         (seq)
  );

  wspd_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .cw_i             (cw),
    .seq_i            (seq),
    .start_i          (start),
    .left_position_i  (left_position_i),
    .right_position_i (right_position_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .left_duty_o      (left_duty_o),
    .left_reverse_o   (left_reverse_o),
    .right_duty_o     (right_duty_o),
    .right_reverse_o  (right_reverse_o)
  );

endmodule

>>> design/wspd_checker.sv
// Port-level checks for wheel_speed_pid_drive, attached by bind.
// Sees the top-level ports only; no package dependency.
`timescale 1ns / 1ps

module wspd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] left_duty_o,
  input logic       left_reverse_o,
  input logic [7:0] right_duty_o,
  input logic       right_reverse_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(left_duty_o)
      && $stable(left_reverse_o) && $stable(right_duty_o) && $stable(right_reverse_o))
    else $error("stalled result changed");

  // an accepted item keeps the block busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accept");

  // no result can appear right after an accept
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("result appeared one cycle after accept");

  // a fresh result frees the input side
  a_result_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o)
    else $error("input still stalled after result");

endmodule

bind wheel_speed_pid_drive wspd_checker u_wspd_checker (.*);
